>>> rtl/core/tst_pkg.sv
// ----------------------------------------------------------------------------
// tst_pkg: shared types and constants of the timer slot table
// Slot count, field widths, command, status and sequencer codes, and the
// request structs of the slot memory.
// ----------------------------------------------------------------------------
`default_nettype none

package tst_pkg;

    localparam int SLOTS     = 32;
    localparam int IDX_W     = $clog2(SLOTS);
    localparam int CNT_W     = $clog2(SLOTS + 1);
    localparam int CMD_W     = 2;
    localparam int STS_W     = 2;
    localparam int TIME_W    = 48;
    localparam int DELAY_W   = 24;
    localparam int TAG_W     = 16;
    localparam int EVID_W    = 8;
    localparam int ID_W      = 7;
    localparam int US_PER_MS = 1000;
    localparam int MUL_W     = $clog2(US_PER_MS + 1);
    localparam int PROD_W    = DELAY_W + MUL_W;

    typedef enum logic [CMD_W-1:0] {
        CMD_SCHEDULE = 2'd0,
        CMD_DELETE   = 2'd1,
        CMD_RUN      = 2'd2,
        CMD_NEXT     = 2'd3
    } cmd_t;

    typedef enum logic [STS_W-1:0] {
        STS_OK     = 2'd0,
        STS_FULL   = 2'd1,
        STS_BAD_ID = 2'd2,
        STS_NONE   = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SCHED,
        S_WRITE,
        S_SCAN,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  idx;
        logic [TIME_W-1:0] deadline;
        logic [TAG_W-1:0]  tag;
    } mem_wr_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
    } mem_rd_t;

endpackage

`default_nettype wire

>>> rtl/core/tst_slot_mem.sv
// ----------------------------------------------------------------------------
// tst_slot_mem: deadline and tag store
// One write port and one registered read port over all slots.
// ----------------------------------------------------------------------------
`default_nettype none

module tst_slot_mem (
    input  logic                          clk,
    input  tst_pkg::mem_wr_t              wr,
    input  tst_pkg::mem_rd_t              rd,
    output logic [tst_pkg::TIME_W-1:0]    rd_deadline,
    output logic [tst_pkg::TAG_W-1:0]     rd_tag
);
    import tst_pkg::*;

    logic [TIME_W+TAG_W-1:0] mem [SLOTS];
    logic [TIME_W+TAG_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.idx] <= {wr.deadline, wr.tag};
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            rd_data_reg <= mem[rd.idx];
        end
    end

    assign rd_deadline = rd_data_reg[TIME_W+TAG_W-1:TAG_W];
    assign rd_tag      = rd_data_reg[TAG_W-1:0];

endmodule

`default_nettype wire

>>> rtl/core/tst_deadline.sv
// ----------------------------------------------------------------------------
// tst_deadline: deadline calculator
// Registered milliseconds-to-microseconds product, then add and saturate.
// ----------------------------------------------------------------------------
`default_nettype none

module tst_deadline (
    input  logic                          clk,
    input  logic [tst_pkg::TIME_W-1:0]    now_us,
    input  logic [tst_pkg::DELAY_W-1:0]   delay_ms,
    output logic [tst_pkg::TIME_W-1:0]    deadline
);
    import tst_pkg::*;

    logic [PROD_W-1:0] prod_reg;
    logic [TIME_W:0]   sum;

    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(delay_ms) * PROD_W'(US_PER_MS);
    end

    assign sum      = {1'b0, now_us} + (TIME_W+1)'(prod_reg);
    assign deadline = sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];

endmodule

`default_nettype wire

>>> rtl/core/timer_slot_table.sv
// Steps: delete is settled in the decode state; schedule searches for a free slot, one slot a
// cycle, then writes it; run and next do one memory read and one 48-bit compare per slot.
// Throughput: one item at a time; the next item is taken once the final result is staged.
// Each run result beyond the first waits for the output register to drain.
// Reset: asynchronous, active low; clears all busy flags and the sequencer, no clearing pass.
// ----------------------------------------------------------------------------
// timer_slot_table: fixed table of timer slots
// Schedule, delete, run-expired and next-deadline commands over a slot table, driven by
// a sequencer scanning one slot per cycle, save run stalls, through a shared comparator.
// ----------------------------------------------------------------------------
`default_nettype none

module timer_slot_table (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [tst_pkg::CMD_W-1:0]     command,
    input  logic [tst_pkg::TIME_W-1:0]    now_us,
    input  logic [tst_pkg::DELAY_W-1:0]   delay_ms,
    input  logic [tst_pkg::TAG_W-1:0]     tag,
    input  logic [tst_pkg::EVID_W-1:0]    event_id,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [tst_pkg::STS_W-1:0]     status,
    output logic [tst_pkg::ID_W-1:0]      slot_id,
    output logic [tst_pkg::TAG_W-1:0]     out_tag,
    output logic [tst_pkg::TIME_W-1:0]    deadline_us,
    output logic                          last
);
    import tst_pkg::*;

    state_t              state_reg, state_next;
    cmd_t                cmd_reg;
    logic [TIME_W-1:0]   now_reg;
    logic [DELAY_W-1:0]  delay_reg;
    logic [TAG_W-1:0]    tag_reg;
    logic [EVID_W-1:0]   event_id_reg;

    logic [SLOTS-1:0]    busy_reg, busy_next;
    logic [CNT_W-1:0]    scan_idx_reg, scan_idx_next;
    logic                eval_vld_reg, eval_vld_next;
    logic [IDX_W-1:0]    eval_idx_reg, eval_idx_next;
    logic                pend_vld_reg, pend_vld_next;

    status_t             res_status_reg, res_status_next;
    logic [ID_W-1:0]     res_id_reg, res_id_next;
    logic [TAG_W-1:0]    res_tag_reg, res_tag_next;
    logic [TIME_W-1:0]   res_dl_reg, res_dl_next;

    logic                out_valid_reg;
    logic [STS_W-1:0]    out_status_reg;
    logic [ID_W-1:0]     out_id_reg;
    logic [TAG_W-1:0]    out_tag_reg;
    logic [TIME_W-1:0]   out_dl_reg;
    logic                out_last_reg;
    logic                out_load, out_last_next, out_free;

    mem_wr_t             mem_wr;
    mem_rd_t             mem_rd;
    logic [TIME_W-1:0]   rd_deadline;
    logic [TAG_W-1:0]    rd_tag;
    logic [TIME_W-1:0]   new_deadline;

    logic [IDX_W-1:0]    scan_slot;
    logic                free_hit, sched_end, issue_more, scan_done;
    logic                eval_busy, run_hit, next_hit, stall;
    logic [TIME_W-1:0]   cmp_a, cmp_b;
    logic                cmp_lt;
    logic                id_zero, id_ok;
    logic [IDX_W-1:0]    del_idx;
    logic                in_accept;

    tst_slot_mem u_mem (
        .clk         (clk),
        .wr          (mem_wr),
        .rd          (mem_rd),
        .rd_deadline (rd_deadline),
        .rd_tag      (rd_tag)
    );

    tst_deadline u_deadline (
        .clk      (clk),
        .now_us   (now_reg),
        .delay_ms (delay_reg),
        .deadline (new_deadline)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign in_accept = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;

    assign scan_slot  = scan_idx_reg[IDX_W-1:0];
    assign free_hit   = !busy_reg[scan_slot];
    assign sched_end  = (scan_idx_reg == CNT_W'(SLOTS - 1));
    assign issue_more = (scan_idx_reg != CNT_W'(SLOTS));
    assign scan_done  = !issue_more && !eval_vld_reg;

    // shared comparator: run tests now < deadline, next tests deadline < best
    assign cmp_a  = (cmd_reg == CMD_RUN) ? now_reg : rd_deadline;
    assign cmp_b  = (cmd_reg == CMD_RUN) ? rd_deadline : res_dl_reg;
    assign cmp_lt = (cmp_a < cmp_b);

    assign eval_busy = busy_reg[eval_idx_reg];
    assign run_hit   = eval_vld_reg && (cmd_reg == CMD_RUN) && eval_busy && !cmp_lt;
    assign next_hit  = eval_vld_reg && (cmd_reg == CMD_NEXT) && eval_busy
                       && (!pend_vld_reg || cmp_lt);
    assign stall     = run_hit && pend_vld_reg && !out_free;

    assign id_zero = (event_id_reg == '0);
    assign id_ok   = (event_id_reg <= EVID_W'(SLOTS));
    assign del_idx = IDX_W'(event_id_reg - EVID_W'(1));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                unique case (cmd_reg) inside
                    CMD_SCHEDULE:     state_next = S_SCHED;
                    CMD_DELETE:       state_next = S_EMIT;
                    CMD_RUN, CMD_NEXT: state_next = S_SCAN;
                    default:          state_next = S_EMIT;
                endcase
            end
            S_SCHED:
            begin
                if (free_hit)
                begin
                    state_next = S_WRITE;
                end
                else if (sched_end)
                begin
                    state_next = S_EMIT;
                end
            end
            S_WRITE:
            begin
                state_next = S_EMIT;
            end
            S_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        busy_next       = busy_reg;
        scan_idx_next   = scan_idx_reg;
        eval_vld_next   = eval_vld_reg;
        eval_idx_next   = eval_idx_reg;
        pend_vld_next   = pend_vld_reg;
        res_status_next = res_status_reg;
        res_id_next     = res_id_reg;
        res_tag_next    = res_tag_reg;
        res_dl_next     = res_dl_reg;
        out_load        = 1'b0;
        out_last_next   = 1'b1;
        mem_wr          = '0;
        mem_rd          = '0;

        unique case (state_reg)
            S_DECODE:
            begin
                scan_idx_next   = '0;
                eval_vld_next   = 1'b0;
                pend_vld_next   = 1'b0;
                res_status_next = STS_OK;
                res_id_next     = '0;
                res_tag_next    = '0;
                res_dl_next     = '0;
                if (cmd_reg == CMD_DELETE)
                begin
                    if (id_zero)
                    begin
                        res_status_next = STS_OK;
                    end
                    else if (id_ok)
                    begin
                        busy_next[del_idx] = 1'b0;
                        res_id_next        = ID_W'(event_id_reg);
                    end
                    else
                    begin
                        res_status_next = STS_BAD_ID;
                    end
                end
            end
            S_SCHED:
            begin
                if (!free_hit)
                begin
                    if (sched_end)
                    begin
                        res_status_next = STS_FULL;
                    end
                    else
                    begin
                        scan_idx_next = scan_idx_reg + CNT_W'(1);
                    end
                end
            end
            S_WRITE:
            begin
                mem_wr.en            = 1'b1;
                mem_wr.idx           = scan_slot;
                mem_wr.deadline      = new_deadline;
                mem_wr.tag           = tag_reg;
                busy_next[scan_slot] = 1'b1;
                res_id_next          = ID_W'(scan_idx_reg) + ID_W'(1);
            end
            S_SCAN:
            begin
                if (!stall)
                begin
                    // issue the next read while the previous slot is evaluated
                    if (issue_more)
                    begin
                        mem_rd.en     = 1'b1;
                        mem_rd.idx    = scan_slot;
                        eval_vld_next = 1'b1;
                        eval_idx_next = scan_slot;
                        scan_idx_next = scan_idx_reg + CNT_W'(1);
                    end
                    else
                    begin
                        eval_vld_next = 1'b0;
                    end
                    if (run_hit)
                    begin
                        busy_next[eval_idx_reg] = 1'b0;
                        if (pend_vld_reg)
                        begin
                            out_load      = 1'b1;
                            out_last_next = 1'b0;
                        end
                        pend_vld_next = 1'b1;
                        res_id_next   = ID_W'(eval_idx_reg) + ID_W'(1);
                        res_tag_next  = rd_tag;
                    end
                    if (next_hit)
                    begin
                        pend_vld_next = 1'b1;
                        res_id_next   = ID_W'(eval_idx_reg) + ID_W'(1);
                        res_dl_next   = rd_deadline;
                    end
                end
                if (scan_done && !pend_vld_reg)
                begin
                    res_status_next = STS_NONE;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_load = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            busy_reg      <= '0;
            scan_idx_reg  <= '0;
            eval_vld_reg  <= 1'b0;
            pend_vld_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            busy_reg     <= busy_next;
            scan_idx_reg <= scan_idx_next;
            eval_vld_reg <= eval_vld_next;
            pend_vld_reg <= pend_vld_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            cmd_reg      <= cmd_t'(command);
            now_reg      <= now_us;
            delay_reg    <= delay_ms;
            tag_reg      <= tag;
            event_id_reg <= event_id;
        end
        eval_idx_reg   <= eval_idx_next;
        res_status_reg <= res_status_next;
        res_id_reg     <= res_id_next;
        res_tag_reg    <= res_tag_next;
        res_dl_reg     <= res_dl_next;
        if (out_load)
        begin
            out_status_reg <= res_status_reg;
            out_id_reg     <= res_id_reg;
            out_tag_reg    <= res_tag_reg;
            out_dl_reg     <= res_dl_reg;
            out_last_reg   <= out_last_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = out_status_reg;
    assign slot_id     = out_id_reg;
    assign out_tag     = out_tag_reg;
    assign deadline_us = out_dl_reg;
    assign last        = out_last_reg;

    a_write_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
        mem_wr.en |-> !busy_reg[mem_wr.idx])
        else $error("schedule wrote a busy slot");

    a_delete_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DECODE && cmd_reg == CMD_DELETE && !id_zero && id_ok)
        |=> !busy_reg[$past(del_idx)])
        else $error("delete left slot busy");

    a_mid_result_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && !out_last_next) |-> (state_reg == S_SCAN && cmd_reg == CMD_RUN))
        else $error("non-final result outside a run scan");

    a_mid_result_keeps_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && !out_last_next) |=> pend_vld_reg)
        else $error("pending run result lost");

    a_no_load_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> out_free)
        else $error("output register overwritten");

endmodule

`default_nettype wire

>>> tb/tb_timer_slot_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_timer_slot_table: self-checking testbench of the timer slot table
// Drives schedule, delete, run and next commands over a valid/ready channel.
// A behavioural copy of the slot table predicts every result, and each result
// is checked field by field in order. It runs directed corner cases, a
// backpressure pass that fills the table, and random traffic under several
// sender and receiver idling mixes.
// ----------------------------------------------------------------------------

module tb_timer_slot_table;

    import tst_pkg::*;

    localparam int          CYCLE_LIMIT = 1000000;
    localparam int          HOLD_CYCLES = 400;
    localparam logic [63:0] MAX_TIME    = {16'h0, {TIME_W{1'b1}}};

    typedef struct {
        status_t           st;
        logic [ID_W-1:0]   id;
        logic [TAG_W-1:0]  tg;
        logic [TIME_W-1:0] dl;
        logic              lst;
    } timer_result_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic [CMD_W-1:0]    command = '0;
    logic [TIME_W-1:0]   now_us = '0;
    logic [DELAY_W-1:0]  delay_ms = '0;
    logic [TAG_W-1:0]    tag = '0;
    logic [EVID_W-1:0]   event_id = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [STS_W-1:0]    status;
    logic [ID_W-1:0]     slot_id;
    logic [TAG_W-1:0]    out_tag;
    logic [TIME_W-1:0]   deadline_us;
    logic                last;

    logic                tbl_busy [SLOTS];
    logic [TIME_W-1:0]   tbl_deadline [SLOTS];
    logic [TAG_W-1:0]    tbl_tag [SLOTS];
    timer_result_t       pending_results [$];

    int unsigned         cycle_count = 0;
    int unsigned         mismatch_count = 0;
    int                  idle_pct = 0;
    int                  stall_pct = 0;
    int                  hold_len = 0;
    logic                hold_go = 1'b0;
    logic                hold_ack = 1'b0;
    int                  hold_cnt = 0;
    logic [TIME_W-1:0]   clock_us = '0;

    timer_slot_table dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .command     (command),
        .now_us      (now_us),
        .delay_ms    (delay_ms),
        .tag         (tag),
        .event_id    (event_id),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .slot_id     (slot_id),
        .out_tag     (out_tag),
        .deadline_us (deadline_us),
        .last        (last)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timer_slot_table regression: fail");
            $finish;
        end
    end

    // hold off for a counted stretch on request, else stall at random
    always @(negedge clk)
    begin
        if (hold_go != hold_ack)
        begin
            hold_ack = hold_go;
            hold_cnt = hold_len;
        end
        if (hold_cnt > 0)
        begin
            out_ready = 1'b0;
            hold_cnt  = hold_cnt - 1;
        end
        else
        begin
            out_ready = ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
        if (mismatch_count < 50)
            $display("mismatch at cycle %0d: %s got %0h expected %0h",
                     cycle_count, field, got, want);
        mismatch_count++;
    endtask

    always @(posedge clk)
    begin
        timer_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch("unexpected result, slot_id", slot_id, 0);
            end
            else
            begin
                want = pending_results.pop_front();
                if (status !== want.st)
                    report_mismatch("status", status, want.st);
                if (slot_id !== want.id)
                    report_mismatch("slot_id", slot_id, want.id);
                if (out_tag !== want.tg)
                    report_mismatch("out_tag", out_tag, want.tg);
                if (deadline_us !== want.dl)
                    report_mismatch("deadline_us", deadline_us, want.dl);
                if (last !== want.lst)
                    report_mismatch("last", last, want.lst);
            end
        end
    end

    task automatic push_result(status_t st, int unsigned id, logic [TAG_W-1:0] tg,
                               logic [TIME_W-1:0] dl, logic lst);
        timer_result_t r;
        r.st  = st;
        r.id  = ID_W'(id);
        r.tg  = tg;
        r.dl  = dl;
        r.lst = lst;
        pending_results.push_back(r);
    endtask

    task automatic predict_table_command(cmd_t cmd, logic [TIME_W-1:0] now,
                                         logic [DELAY_W-1:0] delay, logic [TAG_W-1:0] tg,
                                         logic [EVID_W-1:0] id);
        logic [63:0] sum;
        int          x;
        int          hit;
        case (cmd)
            CMD_SCHEDULE:
            begin
                hit = -1;
                for (x = SLOTS - 1; x >= 0; x--)
                    if (!tbl_busy[x])
                        hit = x;
                if (hit < 0)
                begin
                    push_result(STS_FULL, 0, '0, '0, 1'b1);
                end
                else
                begin
                    sum = 64'(now) + 64'(delay) * 64'(US_PER_MS);
                    if (sum > MAX_TIME)
                        sum = MAX_TIME;
                    tbl_busy[hit]     = 1'b1;
                    tbl_deadline[hit] = sum[TIME_W-1:0];
                    tbl_tag[hit]      = tg;
                    push_result(STS_OK, hit + 1, '0, '0, 1'b1);
                end
            end
            CMD_DELETE:
            begin
                if (id == 0)
                begin
                    push_result(STS_OK, 0, '0, '0, 1'b1);
                end
                else if (id <= SLOTS)
                begin
                    tbl_busy[id - 1] = 1'b0;
                    push_result(STS_OK, id, '0, '0, 1'b1);
                end
                else
                begin
                    push_result(STS_BAD_ID, 0, '0, '0, 1'b1);
                end
            end
            CMD_RUN:
            begin
                hit = -1;
                for (x = 0; x < SLOTS; x++)
                    if (tbl_busy[x] && tbl_deadline[x] <= now)
                        hit = x;
                if (hit < 0)
                    push_result(STS_NONE, 0, '0, '0, 1'b1);
                for (x = 0; x <= hit; x++)
                begin
                    if (tbl_busy[x] && tbl_deadline[x] <= now)
                    begin
                        tbl_busy[x] = 1'b0;
                        push_result(STS_OK, x + 1, tbl_tag[x], '0, x == hit);
                    end
                end
            end
            default:
            begin
                hit = -1;
                for (x = 0; x < SLOTS; x++)
                    if (tbl_busy[x] && (hit < 0 || tbl_deadline[x] < tbl_deadline[hit]))
                        hit = x;
                if (hit < 0)
                    push_result(STS_NONE, 0, '0, '0, 1'b1);
                else
                    push_result(STS_OK, hit + 1, '0, tbl_deadline[hit], 1'b1);
            end
        endcase
    endtask

    // entered and left at a falling edge; valid stays high after acceptance
    task automatic send_command(cmd_t cmd, logic [TIME_W-1:0] now, logic [DELAY_W-1:0] delay,
                                logic [TAG_W-1:0] tg, logic [EVID_W-1:0] id);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        command  = cmd;
        now_us   = now;
        delay_ms = delay;
        tag      = tg;
        event_id = id;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_table_command(cmd, now, delay, tg, id);
        @(negedge clk);
    endtask

    task automatic wait_for_drain();
        in_valid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic test_directed_cases();
        idle_pct  = 0;
        stall_pct = 0;
        send_command(CMD_NEXT, '0, '0, '0, '0);
        send_command(CMD_RUN, '0, '0, '0, '0);
        send_command(CMD_DELETE, '0, '0, '0, 8'd0);
        send_command(CMD_DELETE, '0, '0, '0, EVID_W'(SLOTS + 1));
        send_command(CMD_DELETE, '0, '0, '0, {EVID_W{1'b1}});
        send_command(CMD_DELETE, '0, '0, '0, 8'd1);
        send_command(CMD_SCHEDULE, '0, '0, {TAG_W{1'b1}}, '0);
        send_command(CMD_SCHEDULE, {TIME_W{1'b1}}, {DELAY_W{1'b1}}, '0, {EVID_W{1'b1}});
        send_command(CMD_SCHEDULE, 48'd1000, 24'd5, 16'h1234, '0);
        send_command(CMD_SCHEDULE, 48'd0, 24'd6, 16'hA5C3, '0);
        send_command(CMD_NEXT, 48'd10, '0, '0, '0);
        send_command(CMD_DELETE, 48'd10, '0, '0, 8'd1);
        send_command(CMD_NEXT, 48'd20, '0, '0, '0);
        send_command(CMD_RUN, 48'd5999, '0, '0, '0);
        send_command(CMD_RUN, 48'd6000, '0, '0, '0);
        send_command(CMD_NEXT, 48'd6000, '0, '0, '0);
        send_command(CMD_DELETE, 48'd6000, '0, '0, EVID_W'(SLOTS));
        send_command(CMD_RUN, {TIME_W{1'b1}}, '0, '0, '0);
        send_command(CMD_RUN, 48'd5, '0, '0, '0);
        send_command(CMD_NEXT, 48'd5, '0, '0, '0);
    endtask

    task automatic test_full_table_backpressure();
        int k;
        idle_pct  = 0;
        stall_pct = 0;
        clock_us  = 48'd100000;
        @(posedge clk);
        hold_len = HOLD_CYCLES;
        hold_go  = ~hold_go;
        @(negedge clk);
        for (k = 0; k < SLOTS + 2; k++)
            send_command(CMD_SCHEDULE, clock_us + TIME_W'(k), DELAY_W'($urandom_range(0, 20)),
                         TAG_W'($urandom), EVID_W'($urandom));
        send_command(CMD_NEXT, clock_us, '0, '0, '0);
        send_command(CMD_DELETE, clock_us, '0, '0, EVID_W'($urandom_range(1, SLOTS)));
        send_command(CMD_SCHEDULE, clock_us, 24'd1, 16'h0F0F, '0);
        send_command(CMD_RUN, {TIME_W{1'b1}}, '0, '0, '0);
        wait_for_drain();
        send_command(CMD_NEXT, clock_us, '0, '0, '0);
    endtask

    function automatic logic [EVID_W-1:0] pick_busy_id();
        int start;
        int x;
        start = $urandom_range(0, SLOTS - 1);
        for (x = 0; x < SLOTS; x++)
            if (tbl_busy[(start + x) % SLOTS])
                return EVID_W'((start + x) % SLOTS + 1);
        return EVID_W'($urandom_range(1, SLOTS));
    endfunction

    task automatic test_random_traffic(int idle, int stall, int count);
        int                 k;
        int                 r;
        cmd_t               cmd;
        logic [DELAY_W-1:0] delay;
        logic [EVID_W-1:0]  id;
        idle_pct  = idle;
        stall_pct = stall;
        for (k = 0; k < count; k++)
        begin
            if ($urandom_range(99) < 85)
            begin
                clock_us = clock_us + TIME_W'($urandom_range(0, 3000));
                r = $urandom_range(99);
                if (r < 40)
                    cmd = CMD_SCHEDULE;
                else if (r < 60)
                    cmd = CMD_DELETE;
                else if (r < 80)
                    cmd = CMD_RUN;
                else
                    cmd = CMD_NEXT;
                if ($urandom_range(99) < 85)
                    delay = DELAY_W'($urandom_range(0, 8));
                else
                    delay = DELAY_W'($urandom);
                r = $urandom_range(99);
                if (r < 75)
                    id = pick_busy_id();
                else if (r < 85)
                    id = '0;
                else if (r < 93)
                    id = EVID_W'($urandom_range(1, SLOTS));
                else
                    id = EVID_W'($urandom_range(SLOTS + 1, 255));
                send_command(cmd, clock_us, delay, TAG_W'($urandom), id);
            end
            else
            begin
                send_command(cmd_t'($urandom_range(0, 3)), TIME_W'({$urandom, $urandom}),
                             DELAY_W'($urandom), TAG_W'($urandom), EVID_W'($urandom));
            end
        end
    endtask

    initial
    begin
        int x;
        for (x = 0; x < SLOTS; x++)
        begin
            tbl_busy[x]     = 1'b0;
            tbl_deadline[x] = '0;
            tbl_tag[x]      = '0;
        end
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_cases();
        test_full_table_backpressure();
        clock_us = '0;
        test_random_traffic(0, 0, 35);
        test_random_traffic(56, 0, 35);
        test_random_traffic(0, 56, 35);
        test_random_traffic(7, 7, 35);

        wait_for_drain();
        repeat (SLOTS + 8) @(posedge clk);
        if (mismatch_count == 0)
            $display("timer_slot_table regression: pass");
        else
            $display("timer_slot_table regression: fail");
        $finish;
    end

endmodule

>>> timer_slot_table.f
rtl/core/tst_pkg.sv
rtl/core/tst_slot_mem.sv
rtl/core/tst_deadline.sv
rtl/core/timer_slot_table.sv
tb/tb_timer_slot_table.sv
